// File: hw/rtl/skf_pkg.sv
// ============================================================================
// skf_pkg
// Shared types, constants and the control store for the scalar Kalman filter.
// ============================================================================
package skf_pkg;

    localparam int COV_W   = 20;
    localparam int DEN_W   = COV_W + 1;
    localparam int GAIN_W  = 17;
    localparam int MEAS_W  = 16;
    localparam int EST_W   = 32;
    localparam int ERR_W   = EST_W + 1;
    localparam int PROD_W  = GAIN_W + 1 + ERR_W;
    localparam int CPROD_W = GAIN_W + COV_W;
    localparam int FRAC_W  = 16;
    localparam int STEP_W  = 3;
    localparam int CNT_W   = 5;

    localparam logic [CNT_W-1:0]  DIV_STEPS   = CNT_W'(FRAC_W);
    localparam logic [COV_W-1:0]  COV_MAX     = {COV_W{1'b1}};
    localparam logic [COV_W-1:0]  COV_RESET   = COV_W'(66);
    localparam logic [COV_W-1:0]  Q_RESET     = COV_W'(2621);
    localparam logic [COV_W-1:0]  R_RESET     = COV_W'(13107);
    localparam logic [GAIN_W-1:0] GAIN_ONE    = GAIN_W'(65536);

    // Configuration register indexes.
    localparam logic REG_PROCESS_NOISE     = 1'b0;
    localparam logic REG_MEASUREMENT_NOISE = 1'b1;

    // Datapath operations, one per control word.
    typedef enum logic [3:0] {
        OP_LOAD = 4'd0,
        OP_PRED = 4'd1,
        OP_DEN  = 4'd2,
        OP_DIV  = 4'd3,
        OP_GAIN = 4'd4,
        OP_MUL  = 4'd5,
        OP_UPD  = 4'd6,
        OP_OUT  = 4'd7
    } op_t;

    // Jump conditions; when the condition is false the step counter advances.
    typedef enum logic [1:0] {
        COND_NEVER    = 2'd0,
        COND_NO_INPUT = 2'd1,
        COND_MORE     = 2'd2,
        COND_OUT_BUSY = 2'd3
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

    localparam logic [STEP_W-1:0] STEP_IDLE = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_DIV  = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_OUT  = STEP_W'(7);

    // Control store. The last step falls through to the idle step by wrapping.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        unique case (step)
            3'd0:    w = '{op: OP_LOAD, cond: COND_NO_INPUT, target: STEP_IDLE};
            3'd1:    w = '{op: OP_PRED, cond: COND_NEVER,    target: STEP_IDLE};
            3'd2:    w = '{op: OP_DEN,  cond: COND_NEVER,    target: STEP_IDLE};
            3'd3:    w = '{op: OP_DIV,  cond: COND_MORE,     target: STEP_DIV};
            3'd4:    w = '{op: OP_GAIN, cond: COND_NEVER,    target: STEP_IDLE};
            3'd5:    w = '{op: OP_MUL,  cond: COND_NEVER,    target: STEP_IDLE};
            3'd6:    w = '{op: OP_UPD,  cond: COND_NEVER,    target: STEP_IDLE};
            default: w = '{op: OP_OUT,  cond: COND_OUT_BUSY, target: STEP_OUT};
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/skf_sequencer.sv
// ============================================================================
// skf_sequencer
// Step counter, loop counter and jump logic that walk the control store.
// ============================================================================
module skf_sequencer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  skf_pkg::dp_status_t status,
    output skf_pkg::op_t       op,
    output logic               s_ready
);
    import skf_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    ucode_t            word;
    logic              take_jump;

    assign word    = ucode_rom(step_reg);
    assign op      = word.op;
    assign s_ready = (word.op == OP_LOAD);

    always_comb begin
        unique case (word.cond)
            COND_NEVER:    take_jump = 1'b0;
            COND_NO_INPUT: take_jump = !s_valid;
            COND_MORE:     take_jump = (cnt_reg != CNT_W'(1));
            COND_OUT_BUSY: take_jump = status.out_busy;
            default:       take_jump = 1'b0;
        endcase
    end

    always_comb begin
        step_next = take_jump ? word.target : step_reg + STEP_W'(1);
        cnt_next  = cnt_reg;
        if (word.op == OP_DEN) begin
            cnt_next = DIV_STEPS;
        end else if (word.op == OP_DIV) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
            cnt_reg  <= '0;
        end else begin
            step_reg <= step_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/skf_datapath.sv
// ============================================================================
// skf_datapath
// Filter state, noise registers, serial divider, multipliers and output stage.
// ============================================================================
module skf_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  skf_pkg::op_t                  op,
    output skf_pkg::dp_status_t           status,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [skf_pkg::COV_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    input  logic signed [skf_pkg::MEAS_W-1:0] s_measurement,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [skf_pkg::EST_W-1:0]  m_estimate,
    output logic [skf_pkg::GAIN_W-1:0]    m_gain
);
    import skf_pkg::*;

    logic [COV_W-1:0]          q_reg, r_reg, p_reg, pp_reg;
    logic signed [EST_W-1:0]   x_reg;
    logic signed [MEAS_W-1:0]  meas_reg;
    logic [DEN_W-1:0]          den_reg, rem_reg;
    logic [GAIN_W-1:0]         quo_reg, gain_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [CPROD_W-1:0]        cprod_reg;
    logic                      m_valid_reg;
    logic signed [EST_W-1:0]   m_estimate_reg;
    logic [GAIN_W-1:0]         m_gain_reg;

    logic [DEN_W-1:0]          pred_sum, den_sum;
    logic [DEN_W:0]            trial;
    logic signed [PROD_W-1:0]  rounded;
    logic signed [EST_W+3:0]   step_amt, new_x;
    logic signed [EST_W-1:0]   x_sat;
    logic                      out_busy;

    assign out_busy        = m_valid_reg && !m_ready;
    assign status.out_busy = out_busy;
    assign m_valid         = m_valid_reg;
    assign m_estimate      = m_estimate_reg;
    assign m_gain          = m_gain_reg;

    assign pred_sum = {1'b0, p_reg} + {1'b0, q_reg};
    assign den_sum  = {1'b0, pp_reg} + {1'b0, r_reg};
    assign trial    = {rem_reg, 1'b0};

    // Round to nearest by adding one half, then an arithmetic shift floors.
    assign rounded  = prod_reg + PROD_W'(32768);
    assign step_amt = (EST_W+4)'(rounded >>> FRAC_W);
    assign new_x    = (EST_W+4)'(x_reg) + step_amt;

    always_comb begin
        if (new_x > (EST_W+4)'(signed'({1'b0, {(EST_W-1){1'b1}}}))) begin
            x_sat = {1'b0, {(EST_W-1){1'b1}}};
        end else if (new_x < -(EST_W+4)'(signed'({2'b01, {(EST_W-1){1'b0}}}))) begin
            x_sat = {1'b1, {(EST_W-1){1'b0}}};
        end else begin
            x_sat = new_x[EST_W-1:0];
        end
    end

    // Control state and noise registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg       <= Q_RESET;
            r_reg       <= R_RESET;
            p_reg       <= COV_RESET;
            x_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_PROCESS_NOISE:     q_reg <= cfg_wdata;
                    REG_MEASUREMENT_NOISE: r_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (op == OP_UPD) begin
                x_reg <= x_sat;
                p_reg <= cprod_reg[COV_W+FRAC_W-1:FRAC_W];
            end
            if (op == OP_OUT && !out_busy) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the sequenced datapath.
    always_ff @(posedge aclk) begin
        unique case (op)
            OP_LOAD: begin
                if (s_valid) begin
                    meas_reg <= s_measurement;
                end
            end
            OP_PRED: begin
                pp_reg <= pred_sum[COV_W] ? COV_MAX : pred_sum[COV_W-1:0];
            end
            OP_DEN: begin
                // The integer quotient bit is one only when R is zero.
                den_reg <= den_sum;
                if (r_reg == '0) begin
                    rem_reg <= '0;
                    quo_reg <= GAIN_W'(1);
                end else begin
                    rem_reg <= {1'b0, pp_reg};
                    quo_reg <= '0;
                end
            end
            OP_DIV: begin
                if (trial >= {1'b0, den_reg}) begin
                    rem_reg <= DEN_W'(trial - {1'b0, den_reg});
                    quo_reg <= {quo_reg[GAIN_W-2:0], 1'b1};
                end else begin
                    rem_reg <= trial[DEN_W-1:0];
                    quo_reg <= {quo_reg[GAIN_W-2:0], 1'b0};
                end
            end
            OP_GAIN: begin
                // Both covariances zero: the gain is taken as zero.
                gain_reg <= (den_reg == '0) ? '0 : quo_reg;
                err_reg  <= ERR_W'(signed'({meas_reg, {FRAC_W{1'b0}}})) - ERR_W'(x_reg);
            end
            OP_MUL: begin
                prod_reg  <= PROD_W'(signed'({1'b0, gain_reg})) * PROD_W'(err_reg);
                cprod_reg <= CPROD_W'(GAIN_ONE - gain_reg) * CPROD_W'(pp_reg);
            end
            OP_UPD: ;
            OP_OUT: begin
                if (!out_busy) begin
                    m_estimate_reg <= x_reg;
                    m_gain_reg     <= gain_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: hw/rtl/scalar_kalman_filter.sv
// ============================================================================
// scalar_kalman_filter
// One-dimensional Kalman filter on a signed measurement stream.
// ============================================================================
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | s_measurement (s16 integer)
//  m_      | out       | m_valid / m_ready | m_estimate (s32 Q16.16), m_gain (u17 Q1.16)
//  cfg_    | in        | cfg_wr_en         | cfg_index, cfg_wdata (u20 Q4.16)
//
// Each item walks the control store from the idle step back to it: load, predict,
// denominator, the repeated shift-subtract steps of the serial gain divider, gain, multiply, update and output.
// A result sits in the output register while the next transfer is taken in.
// The sequencer holds on its last step only if the previous result is still
// waiting there. Reset restores the default noise values and filter state.
// ============================================================================
module scalar_kalman_filter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [skf_pkg::COV_W-1:0]         cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [skf_pkg::MEAS_W-1:0] s_measurement,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [skf_pkg::EST_W-1:0]  m_estimate,
    output logic [skf_pkg::GAIN_W-1:0]        m_gain
);
    import skf_pkg::*;

    op_t        op;
    dp_status_t status;

    skf_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .op      (op),
        .s_ready (s_ready)
    );

    skf_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .op            (op),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_measurement (s_measurement),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_estimate    (m_estimate),
        .m_gain        (m_gain)
    );

endmodule
